FILE: sv/pli_pkg.sv
package pli_pkg;

    localparam int DATA_W = 32;             // Q16.16 word
    localparam int DIFF_W = DATA_W + 1;     // difference of two words
    localparam int PROD_W = 2 * DATA_W;     // exact product of two magnitudes
    localparam int MAG_W  = 41;             // capped quotient, 0 .. 2^40
    localparam int SUM_W  = MAG_W + 1;      // y0 plus or minus the quotient
    localparam int PTS_W  = 7;              // points_in_use register
    localparam int IDX_W  = 6;              // entry_index field

    localparam int DIV_STEPS = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [PTS_W-1:0]  PTS_RESET = 7'd2;
    localparam logic [MAG_W-1:0]  MAG_CAP   = 41'h100_0000_0000;
    localparam logic [DATA_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG   = 32'h8000_0000;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

FILE: sv/pli_ram.sv
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pli_div.sv
module pli_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pli_pkg::PROD_W-1:0]   i_dividend,
    input  logic [pli_pkg::DATA_W-1:0]   i_divisor,
    output pli_pkg::t_div_status         o_status,
    output logic [pli_pkg::PROD_W-1:0]   o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [pli_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [pli_pkg::PROD_W-1:0]     r_work;
    logic [pli_pkg::DATA_W-1:0]     r_rem;
    logic [pli_pkg::DATA_W-1:0]     r_dvs;

    logic [pli_pkg::DIFF_W-1:0]     shifted;
    logic [pli_pkg::DIFF_W-1:0]     diff;
    logic                           fits;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign shifted = {r_rem, r_work[pli_pkg::PROD_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_work <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= pli_pkg::DIV_CNT_W'(pli_pkg::DIV_STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_work <= {r_work[pli_pkg::PROD_W-2:0], fits};
                r_rem  <= fits ? diff[pli_pkg::DATA_W-1:0] : shifted[pli_pkg::DATA_W-1:0];
                r_cnt  <= r_cnt - pli_pkg::DIV_CNT_W'(1);
                if (r_cnt == pli_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_work;

endmodule

FILE: sv/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a table of up to MAX_POINTS breakpoints,
// all values signed Q16.16. A transaction on the input channel either writes
// one table entry (req_type 0, done in the accepting cycle, no result) or asks
// a query (req_type 1, exactly one result). A query at or below the first
// breakpoint answers the first y, at or above the last breakpoint in use it
// answers the last y, and otherwise a binary search finds the interval and the
// block answers y0 + dy*dq/dx, quotient truncated toward zero, sum saturated to
// 32 bits. An unsorted table can make the search fail: the result is then 0
// with search_failed set. The time of an interpolated query is set by the
// bit-serial 64-by-32 divider, which produces one quotient bit per cycle, and by
// the single read port of the table memories, which the search uses for one
// breakpoint per cycle. The block accepts no new transaction while a query is in
// progress, but takes the next one while a finished result still waits on the
// output. The points_in_use register (reset value 2) is to be written through
// the configuration channel only while the block is idle; the block itself does
// not enforce this. 0 acts as 1 and values above MAX_POINTS act as MAX_POINTS.
// Table entries hold no reset value: query only entries that have been written.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_req_type,
    input  logic [pli_pkg::IDX_W-1:0]   i_entry_index,
    input  logic signed [31:0]          i_entry_x,
    input  logic signed [31:0]          i_entry_y,
    input  logic signed [31:0]          i_query_x,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [31:0]          o_result_y,
    output logic                        o_search_failed,
    // configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pli_pkg::PTS_W-1:0]   i_cfg_data
);

    // table address width, breakpoint count width and helper widths
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = (NW > pli_pkg::PTS_W) ? NW : pli_pkg::PTS_W;
    localparam int EW = (AW > pli_pkg::IDX_W) ? AW : pli_pkg::IDX_W;
    localparam int IW = AW + 1;     // signed search bounds, hi may reach -1
    localparam int SW = AW + 2;     // lo + hi

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK0,
        S_CHKN,
        S_SRCH,
        S_MIDA,
        S_MIDB,
        S_FA,
        S_FB,
        S_MUL,
        S_DSTART,
        S_DIVW,
        S_DONE
    } t_state;

    function automatic logic [pli_pkg::DATA_W-1:0] abs_diff(
        input logic [pli_pkg::DIFF_W-1:0] v
    );
        logic [pli_pkg::DIFF_W-1:0] neg_v;
        neg_v = -v;
        return v[pli_pkg::DIFF_W-1] ? neg_v[pli_pkg::DATA_W-1:0] : v[pli_pkg::DATA_W-1:0];
    endfunction

    t_state                         r_state;
    logic [pli_pkg::PTS_W-1:0]      r_points;

    logic [pli_pkg::DATA_W-1:0]     r_q;
    logic [AW-1:0]                  r_last;
    logic signed [IW-1:0]           r_lo;
    logic signed [IW-1:0]           r_hi;
    logic [AW-1:0]                  r_mid;
    logic [AW-1:0]                  r_idx;
    logic [pli_pkg::DATA_W-1:0]     r_xm;
    logic [pli_pkg::DATA_W-1:0]     r_x0;
    logic [pli_pkg::DATA_W-1:0]     r_y0;
    logic [pli_pkg::DIFF_W-1:0]     r_dx;
    logic [pli_pkg::DIFF_W-1:0]     r_dy;
    logic [pli_pkg::DIFF_W-1:0]     r_dq;
    logic                           r_neg;
    logic [pli_pkg::PROD_W-1:0]     r_prod;
    logic [pli_pkg::DATA_W-1:0]     r_res_y;
    logic                           r_res_fail;
    logic                           r_out_valid;
    logic [pli_pkg::DATA_W-1:0]     r_out_y;
    logic                           r_out_fail;

    logic [CW-1:0]                  pts_ext;
    logic [NW-1:0]                  n_use;
    logic [AW-1:0]                  last_addr;
    logic [EW-1:0]                  wr_idx_ext;
    logic                           wr_en;
    logic [AW-1:0]                  rd_addr;
    logic [SW-1:0]                  lh_sum;
    logic [AW-1:0]                  mid;
    logic [pli_pkg::DATA_W-1:0]     x_rdata;
    logic [pli_pkg::DATA_W-1:0]     y_rdata;
    logic                           in_take;
    logic                           div_start;
    pli_pkg::t_div_status           div_st;
    logic [pli_pkg::PROD_W-1:0]     quot;
    logic [pli_pkg::MAG_W-1:0]      mag;
    logic [pli_pkg::SUM_W-1:0]      y0_ext;
    logic [pli_pkg::SUM_W-1:0]      sum;
    logic [pli_pkg::DATA_W-1:0]     sat_y;

    // ------------------------------------------------------------------
    // Configuration: points_in_use, accepted in any cycle
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= pli_pkg::PTS_RESET;
        end else if (i_cfg_valid) begin
            r_points <= i_cfg_data;
        end
    end

    // clamp the breakpoint count into 1 .. MAX_POINTS
    always_comb begin
        pts_ext = CW'(r_points);
        if (pts_ext == '0) begin
            n_use = NW'(1);
        end else if (pts_ext > CW'(MAX_POINTS)) begin
            n_use = NW'(MAX_POINTS);
        end else begin
            n_use = NW'(pts_ext);
        end
        last_addr = AW'(n_use - NW'(1));
    end

    // ------------------------------------------------------------------
    // Table memories: written by write transactions, read once per cycle
    // by the search sequencer
    // ------------------------------------------------------------------
    assign in_take    = i_in_valid && o_in_ready;
    assign wr_idx_ext = EW'(i_entry_index);
    // drop writes beyond the table
    assign wr_en      = in_take && (i_req_type == pli_pkg::REQ_WRITE) &&
                        ({26'd0, i_entry_index} < 32'(MAX_POINTS));

    // midpoint of the current search range; both bounds are non-negative here
    assign lh_sum = SW'($unsigned(r_lo)) + SW'($unsigned(r_hi));
    assign mid    = lh_sum[AW:1];

    // read address: the RAM registers the data, which appears in the next state
    always_comb begin
        case (r_state)
            S_CHK0:  rd_addr = r_last;
            S_SRCH:  rd_addr = (r_lo == r_hi) ? r_lo[AW-1:0] : mid;
            S_MIDA:  rd_addr = r_mid + AW'(1);
            S_FA:    rd_addr = r_idx + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    pli_ram #(
        .WIDTH (pli_pkg::DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx_ext[AW-1:0]),
        .i_wdata (i_entry_x),
        .i_raddr (rd_addr),
        .o_rdata (x_rdata)
    );

    pli_ram #(
        .WIDTH (pli_pkg::DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx_ext[AW-1:0]),
        .i_wdata (i_entry_y),
        .i_raddr (rd_addr),
        .o_rdata (y_rdata)
    );

    // ------------------------------------------------------------------
    // Divider: |dy*dq| / |dx|, one quotient bit per cycle
    // ------------------------------------------------------------------
    assign div_start = (r_state == S_DSTART);

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (abs_diff(r_dx)),
        .o_status   (div_st),
        .o_quotient (quot)
    );

    // cap the quotient, apply the sign and saturate
    always_comb begin
        if (quot > pli_pkg::PROD_W'(pli_pkg::MAG_CAP)) begin
            mag = pli_pkg::MAG_CAP;
        end else begin
            mag = quot[pli_pkg::MAG_W-1:0];
        end
        y0_ext = {{(pli_pkg::SUM_W - pli_pkg::DATA_W){r_y0[pli_pkg::DATA_W-1]}}, r_y0};
        sum    = r_neg ? (y0_ext - {1'b0, mag}) : (y0_ext + {1'b0, mag});
        if (sum[pli_pkg::SUM_W-1:pli_pkg::DATA_W-1] == '0 ||
            sum[pli_pkg::SUM_W-1:pli_pkg::DATA_W-1] == '1) begin
            sat_y = sum[pli_pkg::DATA_W-1:0];
        end else begin
            sat_y = sum[pli_pkg::SUM_W-1] ? pli_pkg::SAT_NEG : pli_pkg::SAT_POS;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // release the output slot once the result has been taken; in
            // S_DONE the slot is refilled below instead
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take && (i_req_type == pli_pkg::REQ_QUERY)) begin
                        r_q     <= i_query_x;
                        r_last  <= last_addr;
                        r_state <= S_CHK0;
                    end
                end
                S_CHK0: begin
                    // first breakpoint is on the read port
                    if ($signed(r_q) <= $signed(x_rdata)) begin
                        r_res_y    <= y_rdata;
                        r_res_fail <= 1'b0;
                        r_state    <= S_DONE;
                    end else begin
                        r_state <= S_CHKN;
                    end
                end
                S_CHKN: begin
                    // last breakpoint in use is on the read port
                    if ($signed(r_q) >= $signed(x_rdata)) begin
                        r_res_y    <= y_rdata;
                        r_res_fail <= 1'b0;
                        r_state    <= S_DONE;
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= {1'b0, r_last} - IW'(1);
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_lo == r_hi) begin
                        // narrowed to one interval: take it untested
                        r_idx   <= r_lo[AW-1:0];
                        r_state <= S_FA;
                    end else if (r_lo > r_hi) begin
                        r_res_y    <= '0;
                        r_res_fail <= 1'b1;
                        r_state    <= S_DONE;
                    end else begin
                        r_mid   <= mid;
                        r_state <= S_MIDA;
                    end
                end
                S_MIDA: begin
                    r_xm    <= x_rdata;
                    r_state <= S_MIDB;
                end
                S_MIDB: begin
                    if ($signed(r_xm) <= $signed(r_q) && $signed(r_q) < $signed(x_rdata)) begin
                        // found: collapse the range onto the interval
                        r_lo <= {1'b0, r_mid};
                        r_hi <= {1'b0, r_mid};
                    end else if ($signed(r_q) < $signed(r_xm)) begin
                        r_hi <= {1'b0, r_mid} - IW'(1);
                    end else begin
                        r_lo <= {1'b0, r_mid} + IW'(1);
                    end
                    r_state <= S_SRCH;
                end
                S_FA: begin
                    r_x0    <= x_rdata;
                    r_y0    <= y_rdata;
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_dx    <= {x_rdata[pli_pkg::DATA_W-1], x_rdata} -
                               {r_x0[pli_pkg::DATA_W-1], r_x0};
                    r_dy    <= {y_rdata[pli_pkg::DATA_W-1], y_rdata} -
                               {r_y0[pli_pkg::DATA_W-1], r_y0};
                    r_dq    <= {r_q[pli_pkg::DATA_W-1], r_q} -
                               {r_x0[pli_pkg::DATA_W-1], r_x0};
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_dx == '0) begin
                        // zero-width interval answers its left y
                        r_res_y    <= r_y0;
                        r_res_fail <= 1'b0;
                        r_state    <= S_DONE;
                    end else begin
                        r_prod  <= pli_pkg::PROD_W'(abs_diff(r_dy)) *
                                   pli_pkg::PROD_W'(abs_diff(r_dq));
                        r_neg   <= r_dy[pli_pkg::DIFF_W-1] ^ r_dq[pli_pkg::DIFF_W-1] ^
                                   r_dx[pli_pkg::DIFF_W-1];
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_st.done) begin
                        r_res_y    <= sat_y;
                        r_res_fail <= 1'b0;
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output slot is free or freeing
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_y     <= r_res_y;
                        r_out_fail  <= r_res_fail;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_result_y      = r_out_y;
    assign o_search_failed = r_out_fail;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_search_failed) |-> (o_result_y == '0))
        else $error("failed search delivered a non-zero result");

    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.busy |-> !o_in_ready)
        else $error("input ready while the divider is busy");

    a_query_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_req_type == pli_pkg::REQ_QUERY) |=> !o_in_ready)
        else $error("input ready in the cycle after a query transaction");

    a_write_keeps_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_req_type == pli_pkg::REQ_WRITE) |=> o_in_ready)
        else $error("table write stalled the input channel");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_DEPTH  = 64;
    localparam int QUIET_CYCLES = 120;        // longer than the slowest query
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 72;

    typedef struct {
        logic signed [pli_pkg::DATA_W-1:0] y;
        logic                              failed;
    } t_interp_answer;

    // Private copy of the breakpoint table and the points register, plus the
    // answers owed for queries already accepted but not yet returned.
    class t_interp_scoreboard;
        int                        brk_x [TABLE_DEPTH];
        int                        brk_y [TABLE_DEPTH];
        logic [pli_pkg::PTS_W-1:0] points;
        t_interp_answer            owed_answers [$];
        int                        mismatches;

        function new();
            points     = pli_pkg::PTS_RESET;
            mismatches = 0;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 100)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function void set_points(logic [pli_pkg::PTS_W-1:0] value);
            points = value;
        endfunction

        // 0 behaves as 1, anything above the table depth as the full table
        function int span_points();
            if (points == 0)
                return 1;
            if (points > TABLE_DEPTH)
                return TABLE_DEPTH;
            return int'(points);
        endfunction

        function int outstanding();
            return owed_answers.size();
        endfunction

        function t_interp_answer answer_query(int qx);
            t_interp_answer ans;
            int             n, lo, hi, mid, seg;
            longint         q, x0, x1, y0, y1, dx, dy, dq, res;
            bit [63:0]      ady, adq, adx, mag;
            bit             neg;
            n          = span_points();
            q          = qx;
            ans.y      = '0;
            ans.failed = 1'b0;
            // clamp at both ends of the table in use
            if (q <= brk_x[0]) begin
                ans.y = brk_y[0];
                return ans;
            end
            if (q >= brk_x[n - 1]) begin
                ans.y = brk_y[n - 1];
                return ans;
            end
            // binary search over the intervals; -2 means still searching
            lo  = 0;
            hi  = n - 2;
            seg = -2;
            while (seg == -2) begin
                if (lo == hi) begin
                    seg = lo;
                end else if (lo > hi) begin
                    seg = -1;
                end else begin
                    mid = (lo + hi) / 2;
                    if (brk_x[mid] <= q && q < brk_x[mid + 1])
                        seg = mid;
                    else if (q < brk_x[mid])
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
            end
            if (seg < 0) begin
                ans.failed = 1'b1;
                return ans;
            end
            x0 = brk_x[seg];
            x1 = brk_x[seg + 1];
            y0 = brk_y[seg];
            y1 = brk_y[seg + 1];
            dx = x1 - x0;
            // zero-width interval answers its left ordinate
            if (dx == 0) begin
                ans.y = y0[pli_pkg::DATA_W-1:0];
                return ans;
            end
            dy  = y1 - y0;
            dq  = q - x0;
            neg = ((dy < 0) != (dq < 0)) != (dx < 0);
            if (dy == 0 || dq == 0) begin
                mag = '0;
            end else begin
                // magnitudes stay below 2^32, so the product fits in 64 bits
                ady = (dy < 0) ? -dy : dy;
                adq = (dq < 0) ? -dq : dq;
                adx = (dx < 0) ? -dx : dx;
                mag = (ady * adq) / adx;
                if (mag > pli_pkg::MAG_CAP)
                    mag = 64'(pli_pkg::MAG_CAP);
            end
            res = neg ? y0 - longint'(mag) : y0 + longint'(mag);
            if (res > longint'(int'(pli_pkg::SAT_POS)))
                ans.y = pli_pkg::SAT_POS;
            else if (res < longint'(int'(pli_pkg::SAT_NEG)))
                ans.y = pli_pkg::SAT_NEG;
            else
                ans.y = res[pli_pkg::DATA_W-1:0];
            return ans;
        endfunction

        // Update the table on a write transaction, owe an answer on a query.
        function void note_request(logic kind, logic [pli_pkg::IDX_W-1:0] pos, int ex,
                                   int ey, int qx);
            if (kind == pli_pkg::REQ_WRITE) begin
                brk_x[pos] = ex;
                brk_y[pos] = ey;
            end else begin
                owed_answers.insert(owed_answers.size(), answer_query(qx));
            end
        endfunction

        task check_result(logic signed [pli_pkg::DATA_W-1:0] y, logic failed);
            t_interp_answer want;
            if (owed_answers.size() == 0) begin
                report($sformatf("result y=%h failed=%b with no query outstanding",
                                 y, failed));
                return;
            end
            want = owed_answers.pop_front();
            if (y !== want.y)
                report($sformatf("result_y %h, expected %h", y, want.y));
            if (failed !== want.failed)
                report($sformatf("search_failed %b, expected %b", failed, want.failed));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_req_type;
    logic [pli_pkg::IDX_W-1:0]     i_entry_index;
    logic signed [31:0]            i_entry_x;
    logic signed [31:0]            i_entry_y;
    logic signed [31:0]            i_query_x;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic signed [31:0]            o_result_y;
    logic                          o_search_failed;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [pli_pkg::PTS_W-1:0]     i_cfg_data;

    t_interp_scoreboard board;
    int send_idle_pct = 33;
    int recv_idle_pct = 86;
    int cycle_count   = 0;
    int point_plan [9] = '{1, 64, 0, 127, 2, 3, 65, 17, 40};

    piecewise_linear_interpolator #(
        .MAX_POINTS (TABLE_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_entry_x       (i_entry_x),
        .i_entry_y       (i_entry_y),
        .i_query_x       (i_query_x),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_y      (o_result_y),
        .o_search_failed (o_search_failed),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the result channel at random; the rate follows the current phase.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Sample at the rising edge, before the block updates its outputs.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_result_y, o_search_failed);
    end

    // Drop the run if it hangs well beyond the slowest legal pace.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("piecewise_linear_interpolator test failed");
            $finish;
        end
    end

    // Present one request transaction, idling at random first, and hold it
    // until the block takes it. Valid stays high between back-to-back items.
    task automatic send_request(logic kind, logic [pli_pkg::IDX_W-1:0] pos, int ex,
                                int ey, int qx);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= kind;
        i_entry_index <= pos;
        i_entry_x     <= ex;
        i_entry_y     <= ey;
        i_query_x     <= qx;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        board.note_request(kind, pos, ex, ey, qx);
    endtask

    // Fields a request does not use carry random junk.
    task automatic write_entry(logic [pli_pkg::IDX_W-1:0] pos, int ex, int ey);
        send_request(pli_pkg::REQ_WRITE, pos, ex, ey, $urandom);
    endtask

    task automatic ask_query(int q);
        send_request(pli_pkg::REQ_QUERY, pli_pkg::IDX_W'($urandom), $urandom, $urandom, q);
    endtask

    // Lower valid and hold until every owed answer has come back.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // Write the points register only once the block has gone quiet.
    task automatic write_points(logic [pli_pkg::PTS_W-1:0] value);
        hold_until_drained();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        board.set_points(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Uniform draw in [lo, hi]; fall back to any word when the bounds cross.
    function automatic int pick_between(longint lo, longint hi);
        longint unsigned draw;
        if (hi < lo)
            return $urandom;
        draw = {$urandom, $urandom};
        return int'(lo + longint'(draw % longint'(hi - lo + 1)));
    endfunction

    // Random word shrunk by a random shift, so small and huge values both occur.
    function automatic int scaled_random();
        int draw;
        draw = $urandom;
        return draw >>> $urandom_range(0, 24);
    endfunction

    // Rewrite entries 0 .. count-1 as an ascending table; a narrow spread
    // brings duplicate abscissae, and now and then the range extremes.
    task automatic load_sorted_table(int count);
        int xs [$];
        int x_shift, y_shift;
        x_shift = $urandom_range(0, 24);
        y_shift = $urandom_range(0, 24);
        for (int i = 0; i < count; i++)
            xs.insert(xs.size(), int'($urandom) >>> x_shift);
        if ($urandom_range(0, 3) == 0)
            xs[0] = int'(pli_pkg::SAT_NEG);
        if ($urandom_range(0, 3) == 0)
            xs[count - 1] = int'(pli_pkg::SAT_POS);
        xs.sort();
        for (int i = 0; i < count; i++)
            write_entry(pli_pkg::IDX_W'(i), xs[i], int'($urandom) >>> y_shift);
    endtask

    // Half queries, mostly inside the table span; most writes keep the table
    // in order, the rest are noise anywhere.
    task automatic random_transaction();
        int                        n, pick;
        longint                    lo_b, hi_b;
        logic [pli_pkg::IDX_W-1:0] pos;
        n    = board.span_points();
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            case ($urandom_range(0, 9))
                0:       ask_query($urandom);
                1:       ask_query(board.brk_x[$urandom_range(0, n - 1)]);
                2:       ask_query(board.brk_x[0] - int'($urandom_range(0, 3)));
                3:       ask_query(board.brk_x[n - 1] + int'($urandom_range(0, 3)));
                default: ask_query(pick_between(board.brk_x[0], board.brk_x[n - 1]));
            endcase
        end else if (pick < 88) begin
            pos  = pli_pkg::IDX_W'($urandom);
            lo_b = (pos == 0) ? int'(pli_pkg::SAT_NEG) : board.brk_x[pos - 1];
            hi_b = (pos == TABLE_DEPTH - 1) ? int'(pli_pkg::SAT_POS) : board.brk_x[pos + 1];
            write_entry(pos, pick_between(lo_b, hi_b), scaled_random());
        end else begin
            write_entry(pli_pkg::IDX_W'($urandom), $urandom, $urandom);
        end
    endtask

    initial begin
        int setting;
        int n;
        bit sorted;
        board         = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = pli_pkg::REQ_WRITE;
        i_entry_index = '0;
        i_entry_x     = '0;
        i_entry_y     = '0;
        i_query_x     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, two points in use after reset.
        // Span the whole abscissa range with extreme ordinates.
        write_entry(0, int'(pli_pkg::SAT_NEG), int'(pli_pkg::SAT_NEG));
        write_entry(1, int'(pli_pkg::SAT_POS), int'(pli_pkg::SAT_POS));
        write_entry(pli_pkg::IDX_W'(TABLE_DEPTH - 1), -1, 32'sh5555_5555);
        ask_query(int'(pli_pkg::SAT_NEG));
        ask_query(int'(pli_pkg::SAT_POS));
        ask_query(0);
        ask_query(-1);
        // Steep falling segment one unit wide.
        write_entry(0, 0, int'(pli_pkg::SAT_POS));
        write_entry(1, 32'sh0001_0000, int'(pli_pkg::SAT_NEG));
        ask_query(1);
        ask_query(32'sh0000_8000);
        ask_query(32'sh0000_FFFF);
        ask_query(-5);
        ask_query(32'sh0002_0000);
        // Single point: every query answers the first ordinate.
        write_points(1);
        ask_query(int'(pli_pkg::SAT_NEG));
        ask_query(32'sh0000_4000);
        // Three points, the last two sharing an abscissa.
        write_points(3);
        write_entry(2, 32'sh0001_0000, 5);
        ask_query(32'sh0000_C000);
        ask_query(32'sh0001_0000);
        // Break the ordering of the table.
        write_entry(1, 32'sh0002_0000, 32'sh0010_0000);
        write_entry(2, 32'sh0000_8000, -7);
        ask_query(32'sh0000_4000);

        // Fill every entry so that no query ever reads an unwritten one.
        load_sorted_table(TABLE_DEPTH);

        // Random part: receiver-heavy idling, then sender-heavy, then none.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase / 4)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            setting = (phase < 9) ? point_plan[phase] : $urandom_range(1, TABLE_DEPTH);
            write_points(pli_pkg::PTS_W'(setting));
            // Restore order where noise writes have scrambled the span in use.
            n      = board.span_points();
            sorted = 1'b1;
            for (int i = 1; i < n; i++)
                if (board.brk_x[i] < board.brk_x[i - 1])
                    sorted = 1'b0;
            if (!sorted || $urandom_range(0, 3) == 0)
                load_sorted_table(n);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2 && phase % 3 == 1)
                    hold_until_drained();
                random_transaction();
            end
        end

        hold_until_drained();
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("piecewise_linear_interpolator test passed");
        else
            $display("piecewise_linear_interpolator test failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/pli_pkg.sv
sv/pli_ram.sv
sv/pli_div.sv
sv/piecewise_linear_interpolator.sv
bench/testbench.sv
